### hw/rtl/jspi_pkg.sv
// shared types, constants and lookup functions for the joystick servo integrator
package jspi_pkg;

  localparam int NUM_SERVO   = 6;
  localparam int PULSE_W     = 12;
  localparam int STICK_W     = 8;
  localparam int STAT_W      = 8;
  localparam int LIM_W       = 24;
  localparam int SRV_W       = 3;
  localparam int MV_W        = 2;
  localparam int NUM_STICK   = 4;
  localparam int IN_W        = 40;
  localparam int OUT_W       = NUM_SERVO * (STAT_W + PULSE_W);
  localparam int DIVIDEND_W  = 20;
  localparam int QUOT_W      = 8;
  localparam int CNT_W       = 3;

  // truncating stick map by reciprocal: x*2*half/254 == (x*K) >> 24
  localparam int STEP_MUL_W  = 22;
  localparam int STEP_PROD_W = STICK_W + STEP_MUL_W;
  localparam int STEP_SHIFT  = 24;
  localparam int STEP_Q_W    = STEP_PROD_W - STEP_SHIFT;
  localparam logic [STEP_MUL_W-1:0] STEP_MUL_20 = 22'd2642120;
  localparam logic [STEP_MUL_W-1:0] STEP_MUL_30 = 22'd3963180;
  localparam logic signed [7:0] HALF_20 = 8'sd20;
  localparam logic signed [7:0] HALF_30 = 8'sd30;

  // pwm count by reciprocal: p*128/625 == (p*M) >> 26
  localparam int PWM_MUL_W   = 24;
  localparam int PWM_PROD_W  = PULSE_W + PWM_MUL_W;
  localparam int PWM_SHIFT   = 26;
  localparam logic [PWM_MUL_W-1:0] PWM_MUL = 24'd13743896;

  localparam logic [STAT_W-1:0]  STATUS_MAX = 8'd180;
  localparam logic [STICK_W-1:0] DEAD_LO    = 8'd120;
  localparam logic [STICK_W-1:0] DEAD_HI    = 8'd135;
  localparam logic [STICK_W-1:0] CLAW_CLOSE = 8'd0;
  localparam logic [STICK_W-1:0] CLAW_OPEN  = 8'd1;

  typedef logic [PULSE_W-1:0] pulse_t;
  typedef logic [SRV_W-1:0]   srv_idx_t;
  typedef logic [LIM_W-1:0]   lim_t;

  localparam srv_idx_t SRV_WAIST      = 3'd0;
  localparam srv_idx_t SRV_SHOULDER   = 3'd1;
  localparam srv_idx_t SRV_ELBOW      = 3'd2;
  localparam srv_idx_t SRV_WRIST_TILT = 3'd3;
  localparam srv_idx_t SRV_WRIST_TURN = 3'd4;
  localparam srv_idx_t SRV_GRIPPER    = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_STEP,
    ST_MOVE,
    ST_LOAD,
    ST_DIV,
    ST_OUT
  } state_t;

  // divider result handed back to the sequencer
  typedef struct packed {
    logic              done;
    logic [QUOT_W-1:0] quot;
  } div_res_t;

  // which servo a stick drives, step size and direction
  typedef struct packed {
    srv_idx_t servo;
    logic     wide;
    logic     rev;
  } move_cfg_t;

  function automatic move_cfg_t move_cfg(input logic [MV_W-1:0] idx);
    move_cfg_t c;
    c = '{servo: SRV_WRIST_TURN, wide: 1'b0, rev: 1'b0};
    unique case (idx)
      2'd0: c = '{servo: SRV_WRIST_TURN, wide: 1'b0, rev: 1'b0};
      2'd1: c = '{servo: SRV_WRIST_TILT, wide: 1'b0, rev: 1'b1};
      2'd2: c = '{servo: SRV_WAIST,      wide: 1'b1, rev: 1'b1};
      2'd3: c = '{servo: SRV_ELBOW,      wide: 1'b0, rev: 1'b1};
      default: c = '{servo: SRV_WRIST_TURN, wide: 1'b0, rev: 1'b0};
    endcase
    return c;
  endfunction

  function automatic lim_t lim_reset(input srv_idx_t s);
    lim_t v;
    v = '0;
    unique case (s)
      SRV_WAIST:      v = 24'd10240500;
      SRV_SHOULDER:   v = 24'd7783200;
      SRV_ELBOW:      v = 24'd9831400;
      SRV_WRIST_TILT: v = 24'd9831100;
      SRV_WRIST_TURN: v = 24'd10240500;
      SRV_GRIPPER:    v = 24'd3686910;
      default:        v = '0;
    endcase
    return v;
  endfunction

  function automatic pulse_t pulse_reset(input srv_idx_t s);
    pulse_t v;
    v = '0;
    unique case (s)
      SRV_WAIST:      v = 12'd1500;
      SRV_SHOULDER:   v = 12'd1200;
      SRV_ELBOW:      v = 12'd1900;
      SRV_WRIST_TILT: v = 12'd1500;
      SRV_WRIST_TURN: v = 12'd1600;
      SRV_GRIPPER:    v = 12'd510;
      default:        v = '0;
    endcase
    return v;
  endfunction

endpackage

### hw/rtl/joystick_servo_position_integrator.sv
// top level: servo pulse state, stick step sequencer, status and pwm result assembly
// Items are handled one at a time: four stick moves each pass through a step state
//   and a move state, then each of the six status angles goes through the shared
//   bit-serial divider.
// in_tready is high only between items; the finished result waits in its own
//   output register, so the next item may be accepted while it is pending.
// Reset (rst_n low at a clock edge) restores default limits and pulse widths.
module joystick_servo_position_integrator import jspi_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  // in_tdata: left_stick_x, left_stick_y, claw_code, right_stick_x, right_stick_y
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_W-1:0]   in_tdata,
  // out_tdata: waist, shoulder, elbow, wrist_tilt, wrist_turn, gripper status,
  //   then waist, shoulder, elbow, wrist_tilt, wrist_turn, gripper pwm count
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_W-1:0]  out_tdata,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [SRV_W-1:0]  cfg_index,
  input  logic [LIM_W-1:0]  cfg_data
);

  state_t                  state_r, state_nxt;
  logic [MV_W-1:0]         mv_idx_r;
  srv_idx_t                srv_r;
  lim_t                    lim_r   [NUM_SERVO];
  pulse_t                  pulse_r [NUM_SERVO];
  logic [STICK_W-1:0]      stick_r [NUM_STICK];
  logic [STAT_W-1:0]       res_stat_r [NUM_SERVO];
  pulse_t                  res_pwm_r  [NUM_SERVO];
  logic [STEP_Q_W-1:0]     q_r;
  logic                    skip_r;
  logic                    spec_r;
  logic [STAT_W-1:0]       spec_val_r;
  logic                    out_valid_r;
  logic [OUT_W-1:0]        out_data_r;
  logic [OUT_W-1:0]        out_data_nxt;

  logic                    accept;
  logic                    out_load;
  logic [STICK_W-1:0]      claw;
  move_cfg_t               mcfg;
  srv_idx_t                rd_idx;
  pulse_t                  pulse_rd;
  pulse_t                  lim_mn;
  pulse_t                  lim_mx;
  logic [STICK_W-1:0]      stick_x;
  logic [STEP_PROD_W-1:0]  step_prod;
  logic signed [7:0]       half;
  logic signed [7:0]       step_s;
  logic signed [13:0]      np;
  logic                    in_range;
  logic                    div_start;
  logic [DIVIDEND_W-1:0]   dividend;
  pulse_t                  divisor;
  pulse_t                  diff;
  logic                    spec_nxt;
  logic [STAT_W-1:0]       spec_val_nxt;
  div_res_t                div_res;
  pulse_t                  pwm_count;

  assign claw      = in_tdata[2*STICK_W +: STICK_W];
  assign cfg_ready = 1'b1;

  // shared read port for the servo under work
  assign mcfg     = move_cfg(mv_idx_r);
  assign rd_idx   = (state_r == ST_MOVE) ? mcfg.servo : srv_r;
  assign pulse_rd = pulse_r[rd_idx];
  assign lim_mn   = lim_r[rd_idx][PULSE_W-1:0];
  assign lim_mx   = lim_r[rd_idx][LIM_W-1:PULSE_W];

  // stick step magnitude
  assign stick_x   = stick_r[mv_idx_r];
  assign step_prod = STEP_PROD_W'(stick_x) *
                     STEP_PROD_W'(mcfg.wide ? STEP_MUL_30 : STEP_MUL_20);

  // signed step and candidate pulse
  always_comb begin
    half     = mcfg.wide ? HALF_30 : HALF_20;
    step_s   = mcfg.rev ? (half - $signed({2'b00, q_r})) : ($signed({2'b00, q_r}) - half);
    np       = $signed({2'b00, pulse_rd}) + $signed({{6{step_s[7]}}, step_s});
    in_range = (np > $signed({2'b00, lim_mn})) && (np < $signed({2'b00, lim_mx}));
  end

  // status setup: saturated cases bypass the divider result
  always_comb begin
    diff         = pulse_rd - lim_mn;
    dividend     = DIVIDEND_W'(diff) * DIVIDEND_W'(STATUS_MAX);
    divisor      = lim_mx - lim_mn;
    spec_nxt     = 1'b0;
    spec_val_nxt = '0;
    if ((lim_mx <= lim_mn) || (pulse_rd <= lim_mn)) begin
      spec_nxt     = 1'b1;
      spec_val_nxt = '0;
    end else if (pulse_rd >= lim_mx) begin
      spec_nxt     = 1'b1;
      spec_val_nxt = STATUS_MAX;
    end
  end

  // sequencer state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      mv_idx_r <= '0;
      srv_r    <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        mv_idx_r <= '0;
      end else if (state_r == ST_MOVE) begin
        mv_idx_r <= mv_idx_r + 1'b1;
      end
      if (state_r == ST_MOVE) begin
        srv_r <= '0;
      end else if ((state_r == ST_DIV) && div_res.done) begin
        srv_r <= srv_r + 1'b1;
      end
    end
  end

  // sequencer next state and strobes
  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = ST_STEP;
        end
      end
      ST_STEP: state_nxt = ST_MOVE;
      ST_MOVE: state_nxt = (mv_idx_r == MV_W'(NUM_STICK - 1)) ? ST_LOAD : ST_STEP;
      ST_LOAD: begin
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_res.done) begin
          state_nxt = (srv_r == SRV_W'(NUM_SERVO - 1)) ? ST_OUT : ST_LOAD;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign accept = in_tvalid && in_tready;

  // limit registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SERVO; i++) begin
        lim_r[i] <= lim_reset(SRV_W'(i));
      end
    end else if (cfg_valid && cfg_ready && (cfg_index < SRV_W'(NUM_SERVO))) begin
      lim_r[cfg_index] <= cfg_data;
    end
  end

  // pulse state: claw on accept, stick steps in the move cycles
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SERVO; i++) begin
        pulse_r[i] <= pulse_reset(SRV_W'(i));
      end
    end else if (accept) begin
      if (claw == CLAW_CLOSE) begin
        pulse_r[SRV_GRIPPER] <= lim_r[SRV_GRIPPER][LIM_W-1:PULSE_W];
      end else if (claw == CLAW_OPEN) begin
        pulse_r[SRV_GRIPPER] <= lim_r[SRV_GRIPPER][PULSE_W-1:0];
      end
    end else if ((state_r == ST_MOVE) && !skip_r && in_range) begin
      pulse_r[mcfg.servo] <= np[PULSE_W-1:0];
    end
  end

  // item capture and per-step payload
  always_ff @(posedge clk) begin
    if (accept) begin
      stick_r[0] <= in_tdata[0*STICK_W +: STICK_W];
      stick_r[1] <= in_tdata[1*STICK_W +: STICK_W];
      stick_r[2] <= in_tdata[3*STICK_W +: STICK_W];
      stick_r[3] <= in_tdata[4*STICK_W +: STICK_W];
    end
    if (state_r == ST_STEP) begin
      q_r    <= step_prod[STEP_PROD_W-1:STEP_SHIFT];
      skip_r <= (stick_x >= DEAD_LO) && (stick_x <= DEAD_HI);
    end
    if (state_r == ST_LOAD) begin
      spec_r     <= spec_nxt;
      spec_val_r <= spec_val_nxt;
    end
    if ((state_r == ST_DIV) && div_res.done) begin
      res_stat_r[srv_r] <= spec_r ? spec_val_r : div_res.quot;
      res_pwm_r[srv_r]  <= pwm_count;
    end
  end

  jspi_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .res      (div_res)
  );

  jspi_pwm u_pwm (
    .clk   (clk),
    .en    (div_start),
    .pulse (pulse_rd),
    .count (pwm_count)
  );

  // result packing
  always_comb begin
    out_data_nxt = '0;
    for (int i = 0; i < NUM_SERVO; i++) begin
      out_data_nxt[i*STAT_W +: STAT_W] = res_stat_r[i];
      out_data_nxt[NUM_SERVO*STAT_W + i*PULSE_W +: PULSE_W] = res_pwm_r[i];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // unsaturated status angle never exceeds full scale
  a_quot_range: assert property (@(posedge clk) disable iff (!rst_n)
    (div_res.done && !spec_r) |-> (div_res.quot <= STATUS_MAX))
    else $error("status quotient above full scale");

  // divider finishes only while the sequencer waits for it
  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_res.done |-> (state_r == ST_DIV))
    else $error("divider done outside of divide state");

  // a new result appears only from the output state
  a_out_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == ST_OUT))
    else $error("result loaded outside of output state");

  // an accepted item starts the first stick step
  a_accept_step: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> ((state_r == ST_STEP) && (mv_idx_r == '0)))
    else $error("accepted item did not start stick steps");

endmodule

### hw/rtl/jspi_div.sv
// bit-serial restoring divider, one quotient bit per cycle, 8-bit quotient
module jspi_div import jspi_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  pulse_t                divisor,
  output div_res_t              res
);

  logic [DIVIDEND_W-1:0]       rem_r;
  logic [DIVIDEND_W-2:0]       den_r;
  logic [QUOT_W-1:0]           quot_r;
  logic [CNT_W-1:0]            cnt_r;
  logic                        busy_r;
  logic                        done_r;
  logic                        ge;

  // trial subtract of the aligned divisor
  assign ge = (rem_r >= {1'b0, den_r});

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= CNT_W'(QUOT_W - 1);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  // remainder, shifting divisor and quotient shift register
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= dividend;
      den_r  <= {divisor, (QUOT_W-1)'(0)};
      quot_r <= '0;
    end else if (busy_r) begin
      if (ge) begin
        rem_r <= rem_r - {1'b0, den_r};
      end
      den_r  <= den_r >> 1;
      quot_r <= {quot_r[QUOT_W-2:0], ge};
    end
  end

  assign res.done = done_r;
  assign res.quot = quot_r;

endmodule

### hw/rtl/jspi_pwm.sv
// pulse width to pwm count, registered reciprocal multiply
module jspi_pwm import jspi_pkg::*; (
  input  logic   clk,
  input  logic   en,
  input  pulse_t pulse,
  output pulse_t count
);

  logic [PWM_PROD_W-1:0] prod;
  pulse_t                count_r;

  // floor(p*128/625) from the high bits of p*M
  assign prod = PWM_PROD_W'(pulse) * PWM_PROD_W'(PWM_MUL);

  always_ff @(posedge clk) begin
    if (en) begin
      count_r <= PULSE_W'(prod[PWM_PROD_W-1:PWM_SHIFT]);
    end
  end

  assign count = count_r;

endmodule
